/* rtl/saa_pkg.sv */
// ----------------------------------------------------------------------------
// saa_pkg: shared definitions of the steepest ascent attractor unit
// Sizes of the stamp store, the neighbour codes and the structs that run
// between the top level and the climb sequencer.
// ----------------------------------------------------------------------------
package saa_pkg;

	localparam int MAX_SIDE   = 64;
	localparam int VALUE_BITS = 32;
	localparam int SIDE_BITS  = $clog2(MAX_SIDE);
	localparam int DIM_BITS   = SIDE_BITS + 1;
	localparam int ADDR_BITS  = 2 * SIDE_BITS;
	localparam int DEPTH      = MAX_SIDE * MAX_SIDE;

	typedef logic [SIDE_BITS-1:0]         coord_t;
	typedef logic [DIM_BITS-1:0]          dim_t;
	typedef logic [ADDR_BITS-1:0]         addr_t;
	typedef logic signed [VALUE_BITS-1:0] val_t;

	// Configuration register indexes.
	typedef enum logic {
		REG_WIDTH  = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	// Neighbour order of one climb step: centre first, then left, up, right, down.
	typedef enum logic [2:0] {
		DIR_C = 3'd0,
		DIR_L = 3'd1,
		DIR_U = 3'd2,
		DIR_R = 3'd3,
		DIR_D = 3'd4
	} dir_t;

	typedef struct packed {
		logic   valid;
		coord_t x;
		coord_t y;
		dim_t   w;
		dim_t   h;
	} climb_req_t;

	typedef struct packed {
		logic   valid;
		coord_t origin_x;
		coord_t origin_y;
		coord_t attractor_x;
		coord_t attractor_y;
		logic   outside;
	} climb_res_t;

endpackage

/* rtl/saa_ram.sv */
// ----------------------------------------------------------------------------
// saa_ram: simple dual-port synchronous RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module saa_ram #(
	parameter int DEPTH = 4096,
	parameter int WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* rtl/saa_climb.sv */
// ----------------------------------------------------------------------------
// saa_climb: hill climb sequencer
// Reads the centre and its four neighbours from the stamp store, one per
// cycle, keeps the best so far and moves the centre until it stays best.
// ----------------------------------------------------------------------------
module saa_climb (
	input  logic                clk,
	input  logic                arst_n,
	input  saa_pkg::climb_req_t req,
	output logic                busy,
	output saa_pkg::climb_res_t res,
	input  logic                res_take,
	output logic                rd_en,
	output saa_pkg::addr_t      rd_addr,
	input  saa_pkg::val_t       rd_data
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_STEP = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t          state_q;
	saa_pkg::coord_t cx_q, cy_q, ox_q, oy_q;
	saa_pkg::dim_t   w_q, h_q;
	logic            outside_q;
	logic            iss_on_q;
	saa_pkg::dir_t   iss_dir_q;
	saa_pkg::val_t   best_val_q;
	saa_pkg::dir_t   best_dir_q;
	logic            pend_s1;
	logic            ok_s1;
	saa_pkg::dir_t   idx_s1;

	saa_pkg::coord_t nx, ny;
	logic            nb_ok;
	logic            win;
	saa_pkg::val_t   nb_val;
	saa_pkg::dir_t   nb_dir;

	// Address and bounds check of the neighbour being issued.
	always_comb begin
		nx    = cx_q;
		ny    = cy_q;
		nb_ok = 1'b1;
		case (iss_dir_q)
			saa_pkg::DIR_C: nb_ok = 1'b1;
			saa_pkg::DIR_L: begin
				nx    = cx_q - 1'b1;
				nb_ok = (cx_q != '0);
			end
			saa_pkg::DIR_U: begin
				ny    = cy_q - 1'b1;
				nb_ok = (cy_q != '0);
			end
			saa_pkg::DIR_R: begin
				nx    = cx_q + 1'b1;
				nb_ok = ({1'b0, cx_q} + 1'b1) < w_q;
			end
			saa_pkg::DIR_D: begin
				ny    = cy_q + 1'b1;
				nb_ok = ({1'b0, cy_q} + 1'b1) < h_q;
			end
			default: nb_ok = 1'b0;
		endcase
	end

	assign rd_en   = (state_q == ST_STEP) && iss_on_q;
	assign rd_addr = {ny, nx};

	// Left and up need to be strictly greater; right and down win on a tie.
	always_comb begin
		if ((idx_s1 == saa_pkg::DIR_L) || (idx_s1 == saa_pkg::DIR_U)) begin
			win = ok_s1 && (rd_data > best_val_q);
		end else begin
			win = ok_s1 && (rd_data >= best_val_q);
		end
		if (idx_s1 == saa_pkg::DIR_C) begin
			nb_val = rd_data;
			nb_dir = saa_pkg::DIR_C;
		end else if (win) begin
			nb_val = rd_data;
			nb_dir = idx_s1;
		end else begin
			nb_val = best_val_q;
			nb_dir = best_dir_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_on_q  <= 1'b0;
			iss_dir_q <= saa_pkg::DIR_C;
			pend_s1   <= 1'b0;
		end else begin
			pend_s1 <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						if (({1'b0, req.x} >= req.w) || ({1'b0, req.y} >= req.h)) begin
							state_q <= ST_DONE;
						end else begin
							state_q   <= ST_STEP;
							iss_on_q  <= 1'b1;
							iss_dir_q <= saa_pkg::DIR_C;
						end
					end
				end
				ST_STEP: begin
					if (iss_on_q) begin
						case (iss_dir_q)
							saa_pkg::DIR_C: iss_dir_q <= saa_pkg::DIR_L;
							saa_pkg::DIR_L: iss_dir_q <= saa_pkg::DIR_U;
							saa_pkg::DIR_U: iss_dir_q <= saa_pkg::DIR_R;
							saa_pkg::DIR_R: iss_dir_q <= saa_pkg::DIR_D;
							default: iss_on_q <= 1'b0;
						endcase
					end
					if (pend_s1 && (idx_s1 == saa_pkg::DIR_D)) begin
						if (nb_dir == saa_pkg::DIR_C) begin
							state_q <= ST_DONE;
						end else begin
							iss_on_q  <= 1'b1;
							iss_dir_q <= saa_pkg::DIR_C;
						end
					end
				end
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		ok_s1  <= nb_ok;
		idx_s1 <= iss_dir_q;
		if ((state_q == ST_IDLE) && req.valid) begin
			cx_q      <= req.x;
			cy_q      <= req.y;
			ox_q      <= req.x;
			oy_q      <= req.y;
			w_q       <= req.w;
			h_q       <= req.h;
			outside_q <= ({1'b0, req.x} >= req.w) || ({1'b0, req.y} >= req.h);
		end
		if (pend_s1) begin
			best_val_q <= nb_val;
			best_dir_q <= nb_dir;
			if (idx_s1 == saa_pkg::DIR_D) begin
				case (nb_dir)
					saa_pkg::DIR_L: cx_q <= cx_q - 1'b1;
					saa_pkg::DIR_U: cy_q <= cy_q - 1'b1;
					saa_pkg::DIR_R: cx_q <= cx_q + 1'b1;
					saa_pkg::DIR_D: cy_q <= cy_q + 1'b1;
					default: cx_q <= cx_q;
				endcase
			end
		end
	end

	assign busy            = (state_q != ST_IDLE);
	assign res.valid       = (state_q == ST_DONE);
	assign res.origin_x    = ox_q;
	assign res.origin_y    = oy_q;
	assign res.attractor_x = outside_q ? '0 : cx_q;
	assign res.attractor_y = outside_q ? '0 : cy_q;
	assign res.outside     = outside_q;

	// The walk never leaves the stamp.
	a_centre_inside: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (({1'b0, cx_q} < w_q) && ({1'b0, cy_q} < h_q)))
		else $error("climb centre left the stamp");

	// Read data only comes back while a step is under way.
	a_pend_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == ST_STEP))
		else $error("read data returned outside a climb step");

	// A finished walk is only left when the result is taken.
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DONE) && !res_take) |=> (state_q == ST_DONE) && $stable(cx_q))
		else $error("result dropped before it was taken");

endmodule

/* rtl/steepest_ascent_attractor_unit.sv */
// ----------------------------------------------------------------------------
// steepest_ascent_attractor_unit: steepest ascent hill climb on a stamp
// Loads signed pixel values into a stamp store and, per query, returns the
// local maximum reached by climbing uphill from the start pixel.
//
//   channel | signals                          | direction | handshake
//   --------+----------------------------------+-----------+----------------
//   in      | kind pos_x pos_y pixel_value     | to block  | in_valid/stall
//   out     | origin_x/y attractor_x/y outside | from block| out_valid/stall
//   cfg     | cfg_index cfg_data               | to block  | cfg_valid/ready
//
// A load writes its pixel value into the store. A query climbs from pixel to pixel;
// for each visited pixel the climb reads five store entries through the single read
// port, one per cycle, and compares each entry in the cycle after its read.
// A query outside the stamp reads nothing from the store.
// After reset the width and height are 64; the store content is undefined.
// in_stall is high while a query is climbing or its result waits for the
// output register; the output register frees when out_stall is low.
// ----------------------------------------------------------------------------
module steepest_ascent_attractor_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [5:0]              pos_x,
	input  logic [5:0]              pos_y,
	input  logic signed [31:0]      pixel_value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [5:0]              origin_x,
	output logic [5:0]              origin_y,
	output logic [5:0]              attractor_x,
	output logic [5:0]              attractor_y,
	output logic                    outside,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  saa_pkg::reg_idx_t       cfg_index,
	input  logic [6:0]              cfg_data
);

	saa_pkg::dim_t       width_q, height_q;
	saa_pkg::dim_t       w_eff, h_eff;
	logic                in_acc;
	logic                busy;
	logic                out_valid_q;
	logic                res_take;
	saa_pkg::climb_req_t req;
	saa_pkg::climb_res_t res;
	logic                rd_en;
	saa_pkg::addr_t      rd_addr;
	logic [saa_pkg::VALUE_BITS-1:0] rd_raw;
	saa_pkg::coord_t     ox_q, oy_q, ax_q, ay_q;
	logic                outside_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= saa_pkg::dim_t'(saa_pkg::MAX_SIDE);
			height_q <= saa_pkg::dim_t'(saa_pkg::MAX_SIDE);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				saa_pkg::REG_WIDTH:  width_q  <= cfg_data;
				saa_pkg::REG_HEIGHT: height_q <= cfg_data;
				default: width_q <= width_q;
			endcase
		end
	end

	// Sizes above the store side act as the full side.
	assign w_eff = (width_q > saa_pkg::dim_t'(saa_pkg::MAX_SIDE)) ?
		saa_pkg::dim_t'(saa_pkg::MAX_SIDE) : width_q;
	assign h_eff = (height_q > saa_pkg::dim_t'(saa_pkg::MAX_SIDE)) ?
		saa_pkg::dim_t'(saa_pkg::MAX_SIDE) : height_q;

	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;

	assign req.valid = in_acc && kind;
	assign req.x     = pos_x;
	assign req.y     = pos_y;
	assign req.w     = w_eff;
	assign req.h     = h_eff;

	saa_ram #(
		.DEPTH(saa_pkg::DEPTH),
		.WIDTH(saa_pkg::VALUE_BITS)
	) u_store (
		.clk    (clk),
		.wr_en  (in_acc && !kind),
		.wr_addr({pos_y, pos_x}),
		.wr_data(saa_pkg::VALUE_BITS'(pixel_value)),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_raw)
	);

	saa_climb u_climb (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.busy    (busy),
		.res     (res),
		.res_take(res_take),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (saa_pkg::val_t'(rd_raw))
	);

	// Output register: a finished result moves in when the slot is free or leaving.
	assign res_take = res.valid && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			ox_q      <= res.origin_x;
			oy_q      <= res.origin_y;
			ax_q      <= res.attractor_x;
			ay_q      <= res.attractor_y;
			outside_q <= res.outside;
		end
	end

	assign out_valid   = out_valid_q;
	assign origin_x    = ox_q;
	assign origin_y    = oy_q;
	assign attractor_x = ax_q;
	assign attractor_y = ay_q;
	assign outside     = outside_q;

endmodule

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for steepest_ascent_attractor_unit
// Loads stamps of several shapes and contents, queries start pixels and
// compares every attractor with an in-bench hill-climb predictor, with
// random idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int            RESET_CYCLES  = 11;
	localparam int            SETTLE_CYCLES = 8;
	localparam int            DRAIN_CYCLES  = 64;
	localparam longint        CYCLE_LIMIT   = 5_000_000;
	// Budget of the random phases, loads included.
	localparam int            RANDOM_ITEMS  = 150;
	localparam saa_pkg::val_t VAL_MIN       = 32'sh8000_0000;
	localparam saa_pkg::val_t VAL_MAX       = 32'sh7fff_ffff;

	typedef enum logic {
		KIND_LOAD  = 1'b0,
		KIND_QUERY = 1'b1
	} item_kind_t;

	typedef enum int {
		FILL_NOISE,
		FILL_LEVELS,
		FILL_FLAT,
		FILL_SNAKE,
		FILL_RAMP
	} fill_mode_t;

	typedef struct packed {
		saa_pkg::coord_t origin_x;
		saa_pkg::coord_t origin_y;
		saa_pkg::coord_t attractor_x;
		saa_pkg::coord_t attractor_y;
		logic            outside;
	} peak_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	logic              kind;
	logic [5:0]        pos_x;
	logic [5:0]        pos_y;
	logic signed [31:0] pixel_value;
	logic              out_valid;
	logic              out_stall;
	logic [5:0]        origin_x;
	logic [5:0]        origin_y;
	logic [5:0]        attractor_x;
	logic [5:0]        attractor_y;
	logic              outside;
	logic              cfg_valid;
	logic              cfg_ready;
	saa_pkg::reg_idx_t cfg_index;
	logic [6:0]        cfg_data;

	// Predictor state: a copy of the stamp store and of both size registers.
	saa_pkg::val_t stamp_image [saa_pkg::DEPTH];
	saa_pkg::dim_t width_reg;
	saa_pkg::dim_t height_reg;
	peak_t         peak_q [$];
	peak_t         want_peak;
	int            errors;
	longint        cycle_count;
	bit            idling_on;

	steepest_ascent_attractor_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.origin_x    (origin_x),
		.origin_y    (origin_y),
		.attractor_x (attractor_x),
		.attractor_y (attractor_y),
		.outside     (outside),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int side_of(input saa_pkg::dim_t value);
		return (value > saa_pkg::MAX_SIDE) ? saa_pkg::MAX_SIDE : int'(value);
	endfunction

	// Walks uphill from the start pixel. Left and up need a strictly larger
	// value, right and down also move on a tie, so plateaus drain toward the
	// bottom-right.
	function automatic peak_t climb_to_peak(input saa_pkg::coord_t qx,
			input saa_pkg::coord_t qy);
		peak_t         r;
		int            w, h, cx, cy, steps;
		saa_pkg::dir_t best;
		saa_pkg::val_t best_val;
		w = side_of(width_reg);
		h = side_of(height_reg);
		r.origin_x = qx;
		r.origin_y = qy;
		if (qx >= w || qy >= h) begin
			r.attractor_x = '0;
			r.attractor_y = '0;
			r.outside     = 1'b1;
			return r;
		end
		cx = qx;
		cy = qy;
		for (steps = 0; steps < w * h; steps++) begin
			best     = saa_pkg::DIR_C;
			best_val = stamp_image[cy * saa_pkg::MAX_SIDE + cx];
			if (cx > 0 && stamp_image[cy * saa_pkg::MAX_SIDE + cx - 1] > best_val) begin
				best     = saa_pkg::DIR_L;
				best_val = stamp_image[cy * saa_pkg::MAX_SIDE + cx - 1];
			end
			if (cy > 0 && stamp_image[(cy - 1) * saa_pkg::MAX_SIDE + cx] > best_val) begin
				best     = saa_pkg::DIR_U;
				best_val = stamp_image[(cy - 1) * saa_pkg::MAX_SIDE + cx];
			end
			if (cx + 1 < w && stamp_image[cy * saa_pkg::MAX_SIDE + cx + 1] >= best_val) begin
				best     = saa_pkg::DIR_R;
				best_val = stamp_image[cy * saa_pkg::MAX_SIDE + cx + 1];
			end
			if (cy + 1 < h && stamp_image[(cy + 1) * saa_pkg::MAX_SIDE + cx] >= best_val) begin
				best     = saa_pkg::DIR_D;
				best_val = stamp_image[(cy + 1) * saa_pkg::MAX_SIDE + cx];
			end
			if (best == saa_pkg::DIR_C)
				break;
			case (best)
				saa_pkg::DIR_L: cx = cx - 1;
				saa_pkg::DIR_U: cy = cy - 1;
				saa_pkg::DIR_R: cx = cx + 1;
				default: cy = cy + 1;
			endcase
		end
		r.attractor_x = saa_pkg::coord_t'(cx);
		r.attractor_y = saa_pkg::coord_t'(cy);
		r.outside     = 1'b0;
		return r;
	endfunction

	function automatic saa_pkg::val_t stamp_value(input fill_mode_t mode, input int x,
			input int y, input int w, input saa_pkg::val_t level);
		saa_pkg::val_t v;
		case (mode)
			FILL_NOISE: v = saa_pkg::val_t'($urandom());
			FILL_LEVELS: begin
				case ($urandom_range(0, 3))
					0: v = VAL_MIN;
					1: v = -1;
					2: v = 0;
					default: v = VAL_MAX;
				endcase
			end
			FILL_FLAT: v = level;
			// Serpentine ramp: values rise along a row-by-row serpentine path.
			FILL_SNAKE: v = saa_pkg::val_t'(y * w + (((y % 2) != 0) ? (w - 1 - x) : x) - 1000);
			default: v = saa_pkg::val_t'(x * 7 - y * 3);
		endcase
		return v;
	endfunction

	function automatic void check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (peak_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual origin (%0d,%0d)",
					$time, origin_x, origin_y);
				errors++;
			end else begin
				want_peak = peak_q.pop_front();
				check_field("origin_x", int'(want_peak.origin_x), int'(origin_x));
				check_field("origin_y", int'(want_peak.origin_y), int'(origin_y));
				check_field("attractor_x", int'(want_peak.attractor_x), int'(attractor_x));
				check_field("attractor_y", int'(want_peak.attractor_y), int'(attractor_y));
				check_field("outside", int'(want_peak.outside), int'(outside));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, peak_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: free stretches alternate with stall bursts while idling is on.
	initial begin
		int run;
		out_stall = 1'b0;
		forever begin
			run = $urandom_range(1, 40);
			repeat (run) begin
				@(negedge clk);
				out_stall <= 1'b0;
			end
			if (idling_on && $urandom_range(0, 2) != 0) begin
				run = $urandom_range(1, 16);
				repeat (run) begin
					@(negedge clk);
					out_stall <= 1'b1;
				end
			end
		end
	end

	task automatic send_item(input item_kind_t k, input int x, input int y,
			input saa_pkg::val_t v);
		int gap;
		@(negedge clk);
		in_valid    <= 1'b1;
		kind        <= k;
		pos_x       <= saa_pkg::coord_t'(x);
		pos_y       <= saa_pkg::coord_t'(y);
		pixel_value <= v;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (k == KIND_QUERY)
			peak_q = {peak_q, climb_to_peak(saa_pkg::coord_t'(x), saa_pkg::coord_t'(y))};
		else
			stamp_image[y * saa_pkg::MAX_SIDE + x] = v;
		if (idling_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// A load gives no result, so a few extra cycles cover one still in flight.
	task automatic wait_drained(input int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (peak_q.size() != 0)
			@(posedge clk);
		repeat (extra)
			@(posedge clk);
	endtask

	task automatic write_register(input saa_pkg::reg_idx_t idx, input logic [6:0] data);
		wait_drained(SETTLE_CYCLES);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == saa_pkg::REG_WIDTH)
			width_reg = data;
		else
			height_reg = data;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_stamp_size(input logic [6:0] w_data, input logic [6:0] h_data);
		write_register(saa_pkg::REG_WIDTH, w_data);
		write_register(saa_pkg::REG_HEIGHT, h_data);
	endtask

	task automatic fill_stamp(input fill_mode_t mode, input int w, input int h);
		saa_pkg::val_t level;
		level = saa_pkg::val_t'($urandom());
		for (int y = 0; y < h; y++)
			for (int x = 0; x < w; x++)
				send_item(KIND_LOAD, x, y, stamp_value(mode, x, y, w, level));
	endtask

	task automatic query_inside(input int w, input int h);
		send_item(KIND_QUERY, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
			saa_pkg::val_t'($urandom()));
	endtask

	task automatic query_outside(input int w, input int h);
		int x, y;
		x = $urandom_range(0, 63);
		y = $urandom_range(0, 63);
		if (w < saa_pkg::MAX_SIDE && (h >= saa_pkg::MAX_SIDE || $urandom_range(0, 1) == 1))
			x = $urandom_range(w, 63);
		else if (h < saa_pkg::MAX_SIDE)
			y = $urandom_range(h, 63);
		send_item(KIND_QUERY, x, y, saa_pkg::val_t'($urandom()));
	endtask

	// Mostly queries inside the stamp, some outside it, with stray loads anywhere in the store.
	task automatic mixed_items(input int count, input int w, input int h, input int pause_at);
		int r;
		for (int i = 0; i < count; i++) begin
			if (i == pause_at)
				wait_drained(0);
			r = $urandom_range(0, 9);
			if (r < 7)
				query_inside(w, h);
			else if (r == 7)
				query_outside(w, h);
			else
				send_item(KIND_LOAD, $urandom_range(0, 63), $urandom_range(0, 63),
					saa_pkg::val_t'($urandom()));
		end
	endtask

	task automatic test_directed();
		saa_pkg::val_t grid [9] = '{VAL_MIN, VAL_MIN, 5, 7, 7, 5, VAL_MAX, 7, VAL_MAX};
		set_stamp_size(3, 3);
		for (int i = 0; i < 9; i++)
			send_item(KIND_LOAD, i % 3, i / 3, grid[i]);
		// Loads beyond the stamp still land in the store.
		send_item(KIND_LOAD, 63, 63, VAL_MAX);
		send_item(KIND_LOAD, 5, 0, VAL_MAX);
		send_item(KIND_QUERY, 0, 0, 0);
		send_item(KIND_QUERY, 1, 1, VAL_MIN);
		send_item(KIND_QUERY, 2, 0, VAL_MAX);
		send_item(KIND_QUERY, 0, 1, 0);
		send_item(KIND_QUERY, 2, 2, 0);
		send_item(KIND_QUERY, 1, 0, 0);
		send_item(KIND_QUERY, 63, 0, 0);
		send_item(KIND_QUERY, 0, 63, 0);
	endtask

	task automatic test_register_limits();
		// A zero side makes every query fall outside the stamp.
		set_stamp_size(0, 5);
		send_item(KIND_QUERY, 0, 0, 0);
		query_outside(0, 5);
		query_outside(0, 5);
		set_stamp_size(5, 0);
		send_item(KIND_QUERY, 0, 0, 0);
		query_outside(5, 0);
		// Register values above the largest side act as the largest side.
		set_stamp_size(127, 1);
		fill_stamp(FILL_SNAKE, 64, 1);
		send_item(KIND_QUERY, 0, 0, 0);
		repeat (3) query_inside(64, 1);
		query_outside(64, 1);
		set_stamp_size(1, 64);
		fill_stamp(FILL_LEVELS, 1, 64);
		send_item(KIND_QUERY, 0, 63, 0);
		repeat (4) query_inside(1, 64);
		query_outside(1, 64);
		set_stamp_size(2, 100);
		fill_stamp(FILL_FLAT, 2, 64);
		send_item(KIND_QUERY, 0, 0, 0);
		repeat (2) query_inside(2, 64);
	endtask

	task automatic test_long_climbs();
		set_stamp_size(8, 8);
		fill_stamp(FILL_SNAKE, 8, 8);
		send_item(KIND_QUERY, 0, 0, 0);
		repeat (3) query_inside(8, 8);
		set_stamp_size(10, 6);
		fill_stamp(FILL_RAMP, 10, 6);
		send_item(KIND_QUERY, 0, 5, 0);
		repeat (3) query_inside(10, 6);
		set_stamp_size(12, 12);
		fill_stamp(FILL_FLAT, 12, 12);
		send_item(KIND_QUERY, 0, 0, 0);
		repeat (3) query_inside(12, 12);
	endtask

	task automatic test_random_phases();
		int         sent, phase, w, h, count, pick;
		logic [6:0] w_data, h_data;
		fill_mode_t mode;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				w_data = 7'($urandom_range(33, 100));
				h_data = 7'($urandom_range(1, 2));
			end else if (pick == 1) begin
				w_data = 7'($urandom_range(1, 2));
				h_data = 7'($urandom_range(33, 100));
			end else begin
				w_data = 7'($urandom_range(1, 10));
				h_data = 7'($urandom_range(1, 10));
			end
			w         = side_of(w_data);
			h         = side_of(h_data);
			mode      = fill_mode_t'($urandom_range(0, 4));
			count     = (pick < 2) ? $urandom_range(4, 10) : $urandom_range(10, 40);
			idling_on = ($urandom_range(0, 4) != 0);
			set_stamp_size(w_data, h_data);
			fill_stamp(mode, w, h);
			mixed_items(count, w, h, (phase == 0) ? count / 2 : -1);
			sent  += count + w * h;
			phase += 1;
		end
		idling_on = 1'b1;
	endtask

	task automatic test_steady_stream();
		idling_on = 1'b0;
		set_stamp_size(8, 8);
		fill_stamp(FILL_NOISE, 8, 8);
		mixed_items(40, 8, 8, -1);
	endtask

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		kind        = KIND_LOAD;
		pos_x       = '0;
		pos_y       = '0;
		pixel_value = '0;
		cfg_valid   = 1'b0;
		cfg_index   = saa_pkg::REG_WIDTH;
		cfg_data    = '0;
		width_reg   = 7'd64;
		height_reg  = 7'd64;
		errors      = 0;
		cycle_count = 0;
		idling_on   = 1'b1;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_limits();
		test_long_climbs();
		test_random_phases();
		test_steady_stream();

		wait_drained(DRAIN_CYCLES);
		if (errors == 0 && peak_q.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* sim.f */
rtl/saa_pkg.sv
rtl/saa_ram.sv
rtl/saa_climb.sv
rtl/steepest_ascent_attractor_unit.sv
verif/testbench.sv
